// ===== src/wavp_pkg.sv =====
// ----------------------------------------------------------------------------
// wavp_pkg
// Shared types, record codes and tag table for the WAV header stream parser.
// ----------------------------------------------------------------------------
package wavp_pkg;

  // one input beat: a file byte and its end-of-file flag
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } wavp_in_t;

  // one result beat
  typedef struct packed {
    logic [1:0]  record_kind;
    logic [2:0]  status;
    logic [31:0] sample_word;
    logic        sample_last;
    logic [15:0] audio_format;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] sample_bits;
    logic [31:0] data_size;
  } wavp_out_t;

  // record kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOT_RIFF = 3'd1;
  localparam logic [2:0] ST_NOT_WAVE = 3'd2;
  localparam logic [2:0] ST_NOT_FMT  = 3'd3;
  localparam logic [2:0] ST_NOT_DATA = 3'd4;
  localparam logic [2:0] ST_TRUNC    = 3'd5;

  // chunk tag selectors
  localparam logic [1:0] TAG_RIFF = 2'd0;
  localparam logic [1:0] TAG_WAVE = 2'd1;
  localparam logic [1:0] TAG_FMT  = 2'd2;
  localparam logic [1:0] TAG_DATA = 2'd3;

  // supported sample depths and their sizes in bytes
  localparam logic [15:0] DEPTH_16 = 16'd16;
  localparam logic [15:0] DEPTH_24 = 16'd24;
  localparam logic [1:0]  SIZE_16  = 2'd2;
  localparam logic [1:0]  SIZE_24  = 2'd3;

  // byte count of the fmt fields that are captured
  localparam logic [4:0] FMT_CAPTURE_BYTES = 5'd16;

  // expected byte of a tag at a position
  function automatic logic [7:0] tag_byte(input logic [1:0] sel, input logic [1:0] pos);
    logic [31:0] word;
    unique case (sel)
      TAG_RIFF: word = {8'h46, 8'h46, 8'h49, 8'h52};
      TAG_WAVE: word = {8'h45, 8'h56, 8'h41, 8'h57};
      TAG_FMT:  word = {8'h20, 8'h74, 8'h6D, 8'h66};
      default:  word = {8'h61, 8'h74, 8'h61, 8'h64};
    endcase
    return word[{pos, 3'b000} +: 8];
  endfunction

endpackage

// ===== src/wavp_in_stage.sv =====
// ----------------------------------------------------------------------------
// wavp_in_stage
// Input register: holds one accepted byte beat until the parser takes it.
// ----------------------------------------------------------------------------
module wavp_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wavp_pkg::wavp_in_t in_data,
  output logic              stg_valid,
  output wavp_pkg::wavp_in_t stg_data,
  input  logic              stg_take
);
  import wavp_pkg::*;

  logic     stg_valid_r;
  wavp_in_t stg_data_r;

  // free when empty or being drained this cycle
  assign in_ready  = !stg_valid_r || stg_take;
  assign stg_valid = stg_valid_r;
  assign stg_data  = stg_data_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      stg_valid_r <= 1'b1;
    end else if (stg_take) begin
      stg_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_data_r <= in_data;
    end
  end

endmodule

// ===== src/wavp_parse_core.sv =====
// ----------------------------------------------------------------------------
// wavp_parse_core
// Per-byte parser: chunk phase tracking, fmt capture and sample assembly.
// ----------------------------------------------------------------------------
module wavp_parse_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               stg_valid,
  input  wavp_pkg::wavp_in_t stg_data,
  output logic               stg_take,
  input  logic               slot_free,
  output logic               res_valid,
  output wavp_pkg::wavp_out_t res_data
);
  import wavp_pkg::*;

  typedef enum logic [3:0] {
    PH_RIFF_TAG  = 4'd0,
    PH_RIFF_SIZE = 4'd1,
    PH_WAVE_TAG  = 4'd2,
    PH_FMT_TAG   = 4'd3,
    PH_FMT_SIZE  = 4'd4,
    PH_FMT_BODY  = 4'd5,
    PH_DATA_TAG  = 4'd6,
    PH_DATA_SIZE = 4'd7,
    PH_DATA      = 4'd8,
    PH_DONE      = 4'd9,
    PH_ERROR     = 4'd10
  } phase_t;

  phase_t      phase_r,     phase_nxt;
  logic [1:0]  bif_r,       bif_nxt;
  logic [31:0] shift_r,     shift_nxt;
  logic [31:0] left_r,      left_nxt;
  logic [4:0]  fmt_off_r,   fmt_off_nxt;
  logic [23:0] samp_r,      samp_nxt;
  logic [15:0] fmt_format_r, fmt_format_nxt;
  logic [15:0] fmt_chan_r,  fmt_chan_nxt;
  logic [31:0] fmt_rate_r,  fmt_rate_nxt;
  logic [31:0] fmt_brate_r, fmt_brate_nxt;
  logic [15:0] fmt_align_r, fmt_align_nxt;
  logic [15:0] fmt_bits_r,  fmt_bits_nxt;

  logic        fire;
  logic [7:0]  b;
  logic [1:0]  tag_sel;
  logic [2:0]  tag_err;
  phase_t      tag_next;
  logic [31:0] shift_lane;
  logic [31:0] left_dec;
  logic [1:0]  size;
  logic [23:0] samp_lane;
  logic        is_err;

  assign fire     = stg_valid && slot_free;
  assign stg_take = fire;
  assign b        = stg_data.in_byte;

  // tag selection, error code and follow-on phase for the tag phases
  always_comb begin
    unique case (phase_r)
      PH_RIFF_TAG: begin
        tag_sel = TAG_RIFF; tag_err = ST_NOT_RIFF; tag_next = PH_RIFF_SIZE;
      end
      PH_WAVE_TAG: begin
        tag_sel = TAG_WAVE; tag_err = ST_NOT_WAVE; tag_next = PH_FMT_TAG;
      end
      PH_FMT_TAG: begin
        tag_sel = TAG_FMT;  tag_err = ST_NOT_FMT;  tag_next = PH_FMT_SIZE;
      end
      default: begin
        tag_sel = TAG_DATA; tag_err = ST_NOT_DATA; tag_next = PH_DATA_SIZE;
      end
    endcase
  end

  // byte lane inserts, counter decrement and sample size
  always_comb begin
    shift_lane = shift_r;
    shift_lane[{bif_r, 3'b000} +: 8] = b;
    samp_lane = samp_r;
    if (bif_r != 2'd3) begin
      samp_lane[{bif_r, 3'b000} +: 8] = b;
    end
    left_dec = left_r - 32'd1;
    if (fmt_bits_r == DEPTH_16) begin
      size = SIZE_16;
    end else if (fmt_bits_r == DEPTH_24) begin
      size = SIZE_24;
    end else begin
      size = 2'd0;
    end
  end

  // next state and result for the byte in the input register
  always_comb begin
    phase_nxt      = phase_r;
    bif_nxt        = bif_r;
    shift_nxt      = shift_r;
    left_nxt       = left_r;
    fmt_off_nxt    = fmt_off_r;
    samp_nxt       = samp_r;
    fmt_format_nxt = fmt_format_r;
    fmt_chan_nxt   = fmt_chan_r;
    fmt_rate_nxt   = fmt_rate_r;
    fmt_brate_nxt  = fmt_brate_r;
    fmt_align_nxt  = fmt_align_r;
    fmt_bits_nxt   = fmt_bits_r;
    res_valid      = 1'b0;
    res_data       = '0;
    is_err         = 1'b0;

    unique case (phase_r) inside
      PH_RIFF_TAG, PH_WAVE_TAG, PH_FMT_TAG, PH_DATA_TAG: begin
        if (b != tag_byte(tag_sel, bif_r)) begin
          res_valid            = 1'b1;
          res_data.record_kind = KIND_ERROR;
          res_data.status      = tag_err;
          is_err               = 1'b1;
          phase_nxt            = PH_ERROR;
        end else if (bif_r == 2'd3) begin
          bif_nxt   = 2'd0;
          shift_nxt = '0;
          phase_nxt = tag_next;
        end else begin
          bif_nxt = bif_r + 2'd1;
        end
      end
      PH_RIFF_SIZE, PH_FMT_SIZE, PH_DATA_SIZE: begin
        if (bif_r == 2'd3) begin
          bif_nxt   = 2'd0;
          shift_nxt = '0;
          if (phase_r == PH_RIFF_SIZE) begin
            phase_nxt = PH_WAVE_TAG;
          end else if (phase_r == PH_FMT_SIZE) begin
            left_nxt    = shift_lane;
            fmt_off_nxt = '0;
            phase_nxt   = (shift_lane == '0) ? PH_DATA_TAG : PH_FMT_BODY;
          end else begin
            left_nxt               = shift_lane;
            samp_nxt               = '0;
            res_valid              = 1'b1;
            res_data.record_kind   = KIND_HEADER;
            res_data.status        = ST_OK;
            res_data.audio_format  = fmt_format_r;
            res_data.channel_count = fmt_chan_r;
            res_data.sample_rate   = fmt_rate_r;
            res_data.byte_rate     = fmt_brate_r;
            res_data.block_align   = fmt_align_r;
            res_data.sample_bits   = fmt_bits_r;
            res_data.data_size     = shift_lane;
            phase_nxt              = (shift_lane == '0) ? PH_DONE : PH_DATA;
          end
        end else begin
          bif_nxt   = bif_r + 2'd1;
          shift_nxt = shift_lane;
        end
      end
      PH_FMT_BODY: begin
        // first sixteen body bytes land in the fmt fields
        if (fmt_off_r < FMT_CAPTURE_BYTES) begin
          fmt_off_nxt = fmt_off_r + 5'd1;
          case (fmt_off_r[3:0])
            4'd0:    fmt_format_nxt[7:0]   = b;
            4'd1:    fmt_format_nxt[15:8]  = b;
            4'd2:    fmt_chan_nxt[7:0]     = b;
            4'd3:    fmt_chan_nxt[15:8]    = b;
            4'd4:    fmt_rate_nxt[7:0]     = b;
            4'd5:    fmt_rate_nxt[15:8]    = b;
            4'd6:    fmt_rate_nxt[23:16]   = b;
            4'd7:    fmt_rate_nxt[31:24]   = b;
            4'd8:    fmt_brate_nxt[7:0]    = b;
            4'd9:    fmt_brate_nxt[15:8]   = b;
            4'd10:   fmt_brate_nxt[23:16]  = b;
            4'd11:   fmt_brate_nxt[31:24]  = b;
            4'd12:   fmt_align_nxt[7:0]    = b;
            4'd13:   fmt_align_nxt[15:8]   = b;
            4'd14:   fmt_bits_nxt[7:0]     = b;
            default: fmt_bits_nxt[15:8]    = b;
          endcase
        end
        left_nxt = left_dec;
        if (left_dec == '0) begin
          phase_nxt = PH_DATA_TAG;
        end
      end
      PH_DATA: begin
        left_nxt = left_dec;
        if (size != 2'd0) begin
          if ({1'b0, bif_r} + 3'd1 >= {1'b0, size}) begin
            res_valid            = 1'b1;
            res_data.record_kind = KIND_SAMPLE;
            res_data.status      = ST_OK;
            res_data.sample_word = (size == SIZE_16) ? {16'd0, samp_lane[15:0]}
                                                     : {samp_lane, 8'd0};
            res_data.sample_last = (left_dec < {30'd0, size});
            bif_nxt  = 2'd0;
            samp_nxt = '0;
          end else begin
            bif_nxt  = bif_r + 2'd1;
            samp_nxt = samp_lane;
          end
        end
        if (left_dec == '0) begin
          phase_nxt = PH_DONE;
          bif_nxt   = 2'd0;
          samp_nxt  = '0;
        end
      end
      default: begin
        // after the data or after an error: byte ignored
      end
    endcase

    // end of file: report early end, then return to the start
    if (stg_data.in_last) begin
      if (!is_err && (phase_nxt <= PH_DATA)) begin
        res_valid            = 1'b1;
        res_data             = '0;
        res_data.record_kind = KIND_ERROR;
        res_data.status      = ST_TRUNC;
      end
      phase_nxt      = PH_RIFF_TAG;
      bif_nxt        = '0;
      shift_nxt      = '0;
      left_nxt       = '0;
      fmt_off_nxt    = '0;
      samp_nxt       = '0;
      fmt_format_nxt = '0;
      fmt_chan_nxt   = '0;
      fmt_rate_nxt   = '0;
      fmt_brate_nxt  = '0;
      fmt_align_nxt  = '0;
      fmt_bits_nxt   = '0;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_RIFF_TAG;
      bif_r        <= '0;
      shift_r      <= '0;
      left_r       <= '0;
      fmt_off_r    <= '0;
      samp_r       <= '0;
      fmt_format_r <= '0;
      fmt_chan_r   <= '0;
      fmt_rate_r   <= '0;
      fmt_brate_r  <= '0;
      fmt_align_r  <= '0;
      fmt_bits_r   <= '0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      bif_r        <= bif_nxt;
      shift_r      <= shift_nxt;
      left_r       <= left_nxt;
      fmt_off_r    <= fmt_off_nxt;
      samp_r       <= samp_nxt;
      fmt_format_r <= fmt_format_nxt;
      fmt_chan_r   <= fmt_chan_nxt;
      fmt_rate_r   <= fmt_rate_nxt;
      fmt_brate_r  <= fmt_brate_nxt;
      fmt_align_r  <= fmt_align_nxt;
      fmt_bits_r   <= fmt_bits_nxt;
    end
  end

endmodule

// ===== src/wavp_out_stage.sv =====
// ----------------------------------------------------------------------------
// wavp_out_stage
// Result register: holds one record beat until the consumer takes it.
// ----------------------------------------------------------------------------
module wavp_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic                res_valid,
  input  wavp_pkg::wavp_out_t res_data,
  output logic                slot_free,
  output logic                out_valid,
  input  logic                out_ready,
  output wavp_pkg::wavp_out_t out_data
);
  import wavp_pkg::*;

  logic      out_valid_r;
  wavp_out_t out_data_r;

  // slot usable when empty or being read out this cycle
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      out_data_r <= res_data;
    end
  end

endmodule

// ===== src/wav_header_stream_parser_top.sv =====
// ----------------------------------------------------------------------------
// wav_header_stream_parser_top
// WAV stream parser: checks RIFF/WAVE/fmt/data tags, captures the fmt fields,
// emits a header record and then 16- or 24-bit sample records.
//
//   channel | ports              | beat
//   --------+--------------------+---------------------------------------
//   input   | in_valid/in_ready  | one file byte and its last flag
//   output  | out_valid/out_ready| one header, sample or error record
//
// One byte per cycle sustained while the consumer keeps the result slot free;
// an accepted byte is held in the input register, and its record is loaded
// into the result register as the parser takes the byte from there.
// Reset is synchronous, active low, and returns the parser to the RIFF tag.
// A stalled output holds the parser and, once the input register is full,
// the input; a byte that yields no record still waits for a free result slot.
// ----------------------------------------------------------------------------
module wav_header_stream_parser_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  wavp_pkg::wavp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wavp_pkg::wavp_out_t out_data
);
  import wavp_pkg::*;

  logic      stg_valid;
  wavp_in_t  stg_data;
  logic      stg_take;
  logic      slot_free;
  logic      res_valid;
  wavp_out_t res_data;

  // input register
  wavp_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .stg_valid (stg_valid),
    .stg_data  (stg_data),
    .stg_take  (stg_take)
  );

  // parser
  wavp_parse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .stg_valid (stg_valid),
    .stg_data  (stg_data),
    .stg_take  (stg_take),
    .slot_free (slot_free),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  // result register
  wavp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (stg_take),
    .res_valid (res_valid),
    .res_data  (res_data),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== src/wavp_checker.sv =====
// ----------------------------------------------------------------------------
// wavp_checker
// Port-level checks on the record stream of the WAV parser.
// ----------------------------------------------------------------------------
module wavp_checker (
  input logic                clk,
  input logic                rst_n,
  input wavp_pkg::wavp_out_t out_data,
  input logic                out_valid,
  input logic                out_ready
);
  import wavp_pkg::*;

  // no record straight after reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("record beat right after reset");

  // a stalled record holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled record changed");

  // error records carry a failure status and no payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.record_kind == KIND_ERROR |->
      out_data.status != ST_OK && out_data.status <= ST_TRUNC &&
      out_data.sample_word == '0 && out_data.data_size == '0 &&
      !out_data.sample_last)
    else $error("malformed error record");

  // sample records: ok status and no size, depth or rate header fields
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.record_kind == KIND_SAMPLE |->
      out_data.status == ST_OK && out_data.data_size == '0 &&
      out_data.sample_bits == '0 && out_data.sample_rate == '0)
    else $error("malformed sample record");

  // kind code never out of range, headers never flagged last and always ok
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.record_kind <= KIND_ERROR &&
      (out_data.record_kind != KIND_HEADER ||
       (!out_data.sample_last && out_data.status == ST_OK)))
    else $error("bad record kind or header flags");

endmodule

bind wav_header_stream_parser_top wavp_checker u_wavp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_ready (out_ready)
);

// ===== tb/sv/tb_wav_header_stream_parser_top.sv =====
// ----------------------------------------------------------------------------
// tb_wav_header_stream_parser_top
// Self-checking bench for the WAV stream parser. WAV files are built byte by
// byte: well-formed ones with random fmt fields, depths and data lengths,
// plus truncated files, corrupted tags, oversized chunk lengths and noise.
// The files are streamed in under random idling on both channels. An internal
// parser model predicts every header, sample and error record, and each
// record that comes out is checked field by field against the oldest one due.
// ----------------------------------------------------------------------------
module tb_wav_header_stream_parser_top;
  import wavp_pkg::*;

  localparam int CLK_HALF        = 10;
  localparam int RESET_CYCLES    = 9;
  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_CYCLES     = 400;
  localparam int HOLD_AFTER_RECS = 40;
  localparam int DRAIN_CYCLES    = 10;
  localparam int REPORT_MAX      = 10;

  // parser phases of the model
  typedef enum logic [3:0] {
    SEEK_RIFF   = 4'd0,
    RIFF_LEN    = 4'd1,
    SEEK_WAVE   = 4'd2,
    SEEK_FMT    = 4'd3,
    FMT_LEN     = 4'd4,
    FMT_BODY    = 4'd5,
    SEEK_DATA   = 4'd6,
    DATA_LEN    = 4'd7,
    DATA_BODY   = 4'd8,
    AFTER_DATA  = 4'd9,
    AFTER_ERROR = 4'd10
  } parse_phase_t;

  // chunk tags, by selector and then by character from the top
  localparam logic [3:0][3:0][7:0] CHUNK_TAGS = {"data", "fmt ", "WAVE", "RIFF"};

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  wavp_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  wavp_out_t out_data;

  wav_header_stream_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // bench state
  wavp_in_t   bytes_to_send[$];
  wavp_out_t  records_due[$];
  logic [7:0] file_q[$];
  int         bytes_queued  = 0;
  int         records_seen  = 0;
  int         mismatches    = 0;
  int         snd_idle_pct  = 0;
  int         rcv_idle_pct  = 0;
  int         hold_left     = 0;
  bit         hold_done     = 1'b0;
  bit         in_taken      = 1'b0;
  int         stall_cycles  = 0;

  // parser model state
  parse_phase_t ph_now;
  logic [1:0]   pos_in_field;
  logic [31:0]  len_acc;
  logic [31:0]  left_count;
  logic [31:0]  fmt_chunk_len;
  logic [15:0]  cap_format;
  logic [15:0]  cap_channels;
  logic [31:0]  cap_rate;
  logic [31:0]  cap_byte_rate;
  logic [15:0]  cap_align;
  logic [15:0]  cap_bits;
  logic [23:0]  smp_acc;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // back to the start of a file
  task automatic restart_parser();
    ph_now        = SEEK_RIFF;
    pos_in_field  = '0;
    len_acc       = '0;
    left_count    = '0;
    fmt_chunk_len = '0;
    cap_format    = '0;
    cap_channels  = '0;
    cap_rate      = '0;
    cap_byte_rate = '0;
    cap_align     = '0;
    cap_bits      = '0;
    smp_acc       = '0;
  endtask

  // model one accepted byte and queue the record it causes, if any
  task automatic parse_wav_byte(input wavp_in_t beat);
    wavp_out_t   rec;
    logic        emit;
    logic        tag_check;
    logic        tag_bad;
    logic [1:0]  tag_sel;
    logic [2:0]  tag_fault;
    logic [31:0] off;
    logic [1:0]  smp_size;
    rec       = '0;
    emit      = 1'b0;
    tag_check = 1'b1;
    tag_bad   = 1'b0;
    tag_sel   = TAG_RIFF;
    tag_fault = ST_NOT_RIFF;
    off       = '0;
    smp_size  = '0;
    case (ph_now)
      SEEK_RIFF: begin
        tag_sel   = TAG_RIFF;
        tag_fault = ST_NOT_RIFF;
      end
      SEEK_WAVE: begin
        tag_sel   = TAG_WAVE;
        tag_fault = ST_NOT_WAVE;
      end
      SEEK_FMT: begin
        tag_sel   = TAG_FMT;
        tag_fault = ST_NOT_FMT;
      end
      SEEK_DATA: begin
        tag_sel   = TAG_DATA;
        tag_fault = ST_NOT_DATA;
      end
      default: tag_check = 1'b0;
    endcase

    if (tag_check) begin
      // tag bytes: first wrong byte raises the error
      if (beat.in_byte != CHUNK_TAGS[tag_sel][2'd3 - pos_in_field]) begin
        rec.record_kind = KIND_ERROR;
        rec.status      = tag_fault;
        emit            = 1'b1;
        tag_bad         = 1'b1;
        ph_now          = AFTER_ERROR;
      end else if (pos_in_field == 2'd3) begin
        pos_in_field = '0;
        len_acc      = '0;
        ph_now       = parse_phase_t'(ph_now + 4'd1);
      end else begin
        pos_in_field = pos_in_field + 2'd1;
      end
    end else if (ph_now == RIFF_LEN || ph_now == FMT_LEN || ph_now == DATA_LEN) begin
      // little-endian length fields
      len_acc[{pos_in_field, 3'b000} +: 8] = beat.in_byte;
      if (pos_in_field == 2'd3) begin
        pos_in_field = '0;
        case (ph_now)
          RIFF_LEN: ph_now = SEEK_WAVE;
          FMT_LEN: begin
            fmt_chunk_len = len_acc;
            left_count    = len_acc;
            if (len_acc == 0) ph_now = SEEK_DATA;
            else ph_now = FMT_BODY;
          end
          default: begin
            left_count        = len_acc;
            smp_acc           = '0;
            rec.record_kind   = KIND_HEADER;
            rec.status        = ST_OK;
            rec.audio_format  = cap_format;
            rec.channel_count = cap_channels;
            rec.sample_rate   = cap_rate;
            rec.byte_rate     = cap_byte_rate;
            rec.block_align   = cap_align;
            rec.sample_bits   = cap_bits;
            rec.data_size     = len_acc;
            emit              = 1'b1;
            if (len_acc == 0) ph_now = AFTER_DATA;
            else ph_now = DATA_BODY;
          end
        endcase
        len_acc = '0;
      end else begin
        pos_in_field = pos_in_field + 2'd1;
      end
    end else if (ph_now == FMT_BODY) begin
      // first sixteen fmt bytes are captured, the rest skipped
      off = fmt_chunk_len - left_count;
      if (off < 2) cap_format[{off[0], 3'b000} +: 8] = beat.in_byte;
      else if (off < 4) cap_channels[{off[0], 3'b000} +: 8] = beat.in_byte;
      else if (off < 8) cap_rate[{off[1:0], 3'b000} +: 8] = beat.in_byte;
      else if (off < 12) cap_byte_rate[{off[1:0], 3'b000} +: 8] = beat.in_byte;
      else if (off < 14) cap_align[{off[0], 3'b000} +: 8] = beat.in_byte;
      else if (off < 16) cap_bits[{off[0], 3'b000} +: 8] = beat.in_byte;
      left_count = left_count - 1;
      if (left_count == 0) ph_now = SEEK_DATA;
    end else if (ph_now == DATA_BODY) begin
      // sample assembly, only for 16- and 24-bit depths
      if (cap_bits == DEPTH_16) smp_size = SIZE_16;
      else if (cap_bits == DEPTH_24) smp_size = SIZE_24;
      left_count = left_count - 1;
      if (smp_size != 0) begin
        smp_acc[{pos_in_field, 3'b000} +: 8] = beat.in_byte;
        if ({1'b0, pos_in_field} + 3'd1 >= {1'b0, smp_size}) begin
          rec.record_kind = KIND_SAMPLE;
          rec.status      = ST_OK;
          if (smp_size == SIZE_16) rec.sample_word = {16'h0000, smp_acc[15:0]};
          else rec.sample_word = {smp_acc, 8'h00};
          rec.sample_last = (left_count < smp_size);
          emit            = 1'b1;
          pos_in_field    = '0;
          smp_acc         = '0;
        end else begin
          pos_in_field = pos_in_field + 2'd1;
        end
      end
      if (left_count == 0) begin
        ph_now       = AFTER_DATA;
        pos_in_field = '0;
        smp_acc      = '0;
      end
    end

    // end of file: early end overrides any record of this byte
    if (beat.in_last) begin
      if (!tag_bad && ph_now <= DATA_BODY) begin
        rec             = '0;
        rec.record_kind = KIND_ERROR;
        rec.status      = ST_TRUNC;
        emit            = 1'b1;
      end
      restart_parser();
    end
    if (emit) records_due.push_back(rec);
  endtask

  // list of differing fields with expected/actual values
  function automatic string field_diffs(input wavp_out_t want, input wavp_out_t got);
    string s;
    s = "";
    if (want.record_kind !== got.record_kind)
      s = {s, $sformatf(" record_kind %0h/%0h", want.record_kind, got.record_kind)};
    if (want.status !== got.status)
      s = {s, $sformatf(" status %0h/%0h", want.status, got.status)};
    if (want.sample_word !== got.sample_word)
      s = {s, $sformatf(" sample_word %h/%h", want.sample_word, got.sample_word)};
    if (want.sample_last !== got.sample_last)
      s = {s, $sformatf(" sample_last %0h/%0h", want.sample_last, got.sample_last)};
    if (want.audio_format !== got.audio_format)
      s = {s, $sformatf(" audio_format %h/%h", want.audio_format, got.audio_format)};
    if (want.channel_count !== got.channel_count)
      s = {s, $sformatf(" channel_count %h/%h", want.channel_count, got.channel_count)};
    if (want.sample_rate !== got.sample_rate)
      s = {s, $sformatf(" sample_rate %h/%h", want.sample_rate, got.sample_rate)};
    if (want.byte_rate !== got.byte_rate)
      s = {s, $sformatf(" byte_rate %h/%h", want.byte_rate, got.byte_rate)};
    if (want.block_align !== got.block_align)
      s = {s, $sformatf(" block_align %h/%h", want.block_align, got.block_align)};
    if (want.sample_bits !== got.sample_bits)
      s = {s, $sformatf(" sample_bits %h/%h", want.sample_bits, got.sample_bits)};
    if (want.data_size !== got.data_size)
      s = {s, $sformatf(" data_size %h/%h", want.data_size, got.data_size)};
    return s;
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("error: %s", msg);
  endtask

  // file building
  task automatic add_bytes(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) file_q.push_back(v[8*i +: 8]);
  endtask

  task automatic add_tag(input logic [1:0] sel);
    for (int p = 0; p < 4; p++) file_q.push_back(CHUNK_TAGS[sel][3 - p]);
  endtask

  // move the built file into the send queue, last flag on its final byte
  task automatic ship_file();
    wavp_in_t beat;
    for (int i = 0; i < file_q.size(); i++) begin
      beat.in_byte = file_q[i];
      beat.in_last = (i == file_q.size() - 1);
      bytes_to_send.push_back(beat);
    end
    bytes_queued += file_q.size();
    file_q.delete();
  endtask

  // short error files: bad first byte, bytes after an error, early end, bad WAVE
  task automatic directed_files();
    add_bytes(32'h00, 1);
    file_q[0] = 8'h00;
    ship_file();
    add_bytes(32'h52_FF_49_52, 4);
    ship_file();
    add_bytes(32'h52, 1);
    ship_file();
    add_tag(TAG_RIFF);
    add_bytes(32'hFFFF_FFFF, 4);
    add_bytes(32'h0056_4157, 4);
    ship_file();
  endtask

  // one random file: mostly well formed, some cut short, oversized, bad tags or noise
  task automatic random_file();
    int          shape;
    int          r;
    int          fmt_n;
    int          data_n;
    int          trail_n;
    int          cut;
    int          spot;
    logic [31:0] fmt_decl;
    logic [31:0] data_decl;
    logic [15:0] depth;
    logic [15:0] fmt_code;
    logic [15:0] chans;
    logic [127:0] fmt_image;
    shape = $urandom_range(0, 99);

    if (shape >= 90) begin
      if ($urandom_range(0, 1)) add_tag(TAG_RIFF);
      for (int i = $urandom_range(1, 20); i > 0; i--) file_q.push_back(8'($urandom()));
      ship_file();
      return;
    end

    r = $urandom_range(0, 9);
    if (r < 4) depth = DEPTH_16;
    else if (r < 8) depth = DEPTH_24;
    else depth = 16'($urandom());
    r = $urandom_range(0, 19);
    if (r == 0) fmt_decl = 0;
    else if (r < 3) fmt_decl = $urandom_range(1, 15);
    else if (r < 16) fmt_decl = 16;
    else fmt_decl = $urandom_range(17, 24);
    fmt_n     = fmt_decl;
    data_n    = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
    data_decl = data_n;
    trail_n   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    // oversized chunk lengths: the file runs out inside the chunk
    if (shape >= 60 && shape < 70) begin
      trail_n = 0;
      if ($urandom_range(0, 1)) data_decl = $urandom();
      else begin
        fmt_decl = $urandom();
        fmt_n    = $urandom_range(0, 20);
      end
    end

    fmt_code  = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'd1;
    chans     = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 8));
    fmt_image = {depth, 16'($urandom()), 32'($urandom()), 32'($urandom()), chans, fmt_code};

    add_tag(TAG_RIFF);
    add_bytes($urandom(), 4);
    add_tag(TAG_WAVE);
    add_tag(TAG_FMT);
    add_bytes(fmt_decl, 4);
    for (int i = 0; i < fmt_n; i++)
      file_q.push_back((i < 16) ? fmt_image[8*i +: 8] : 8'($urandom()));
    add_tag(TAG_DATA);
    add_bytes(data_decl, 4);
    for (int i = 0; i < data_n + trail_n; i++) file_q.push_back(8'($urandom()));

    if (shape >= 70 && shape < 80) begin
      // early end anywhere in the file
      cut = $urandom_range(1, file_q.size() - 1);
      while (file_q.size() > cut) void'(file_q.pop_back());
    end else if (shape >= 80) begin
      // one tag byte corrupted
      case ($urandom_range(0, 3))
        0: spot = 0;
        1: spot = 8;
        2: spot = 12;
        default: spot = 20 + fmt_n;
      endcase
      spot = spot + $urandom_range(0, 3);
      file_q[spot] = file_q[spot] ^ 8'($urandom_range(1, 255));
    end
    ship_file();
  endtask

  // sender: new beat at the falling edge once the last one was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (bytes_to_send.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
        in_data  <= bytes_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random ready, plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && records_seen >= HOLD_AFTER_RECS) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // monitor: check result beats, feed accepted input beats to the model
  always @(posedge clk) begin : monitor
    wavp_out_t want;
    string     diffs;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      records_seen++;
      if (records_due.size() == 0) begin
        flag_error($sformatf("record with nothing expected: %h", out_data));
      end else begin
        want  = records_due.pop_front();
        diffs = field_diffs(want, out_data);
        if (diffs != "") flag_error({"record mismatch (expected/actual):", diffs});
      end
    end
    if (rst_n && in_valid && in_ready) parse_wav_byte(in_data);
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("wav_header_stream_parser_top regression: fail");
        $finish;
      end
    end
  end

  // reset, then three idling phases of random files
  initial begin
    restart_parser();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    snd_idle_pct = 36;
    rcv_idle_pct = 55;
    directed_files();
    while (bytes_queued < 700) random_file();
    while (bytes_to_send.size() != 0) @(posedge clk);

    snd_idle_pct = 55;
    rcv_idle_pct = 36;
    while (bytes_queued < 1350) random_file();
    while (bytes_to_send.size() != 0) @(posedge clk);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    while (bytes_queued < 2000) random_file();

    // drain: everything sent and every record back
    while (bytes_to_send.size() != 0 || in_valid || records_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && records_due.size() == 0)
      $display("wav_header_stream_parser_top regression: pass");
    else
      $display("wav_header_stream_parser_top regression: fail");
    $finish;
  end

endmodule
